// ----- src/smmi0_pkg.sv -----
package smmi0_pkg;

    typedef struct packed {
        logic [4:0]  action;
        logic [63:0] src_a_lo;
        logic [63:0] src_a_hi;
        logic [63:0] src_b_lo;
        logic [63:0] src_b_hi;
    } t_in_item;

    typedef struct packed {
        logic [63:0] result_lo;
        logic [63:0] result_hi;
        logic        reserved_op;
    } t_out_item;

    // operation codes, group table order
    localparam logic [4:0] OP_PADDW  = 5'd0;
    localparam logic [4:0] OP_PSUBW  = 5'd1;
    localparam logic [4:0] OP_PCGTW  = 5'd2;
    localparam logic [4:0] OP_PMAXW  = 5'd3;
    localparam logic [4:0] OP_PADDH  = 5'd4;
    localparam logic [4:0] OP_PSUBH  = 5'd5;
    localparam logic [4:0] OP_PCGTH  = 5'd6;
    localparam logic [4:0] OP_PMAXH  = 5'd7;
    localparam logic [4:0] OP_PADDB  = 5'd8;
    localparam logic [4:0] OP_PSUBB  = 5'd9;
    localparam logic [4:0] OP_PCGTB  = 5'd10;
    localparam logic [4:0] OP_PADDSW = 5'd16;
    localparam logic [4:0] OP_PSUBSW = 5'd17;
    localparam logic [4:0] OP_PEXTLW = 5'd18;
    localparam logic [4:0] OP_PPACW  = 5'd19;
    localparam logic [4:0] OP_PADDSH = 5'd20;
    localparam logic [4:0] OP_PSUBSH = 5'd21;
    localparam logic [4:0] OP_PEXTLH = 5'd22;
    localparam logic [4:0] OP_PPACH  = 5'd23;
    localparam logic [4:0] OP_PADDSB = 5'd24;
    localparam logic [4:0] OP_PSUBSB = 5'd25;
    localparam logic [4:0] OP_PEXTLB = 5'd26;
    localparam logic [4:0] OP_PPACB  = 5'd27;
    localparam logic [4:0] OP_PEXT5  = 5'd30;
    localparam logic [4:0] OP_PPAC5  = 5'd31;

    typedef enum logic [2:0] {
        LK_ADD  = 3'd0,
        LK_SUB  = 3'd1,
        LK_CGT  = 3'd2,
        LK_MAX  = 3'd3,
        LK_ADDS = 3'd4,
        LK_SUBS = 3'd5
    } t_lane_kind;

endpackage

// ----- src/smmi0_lane.sv -----
module smmi0_lane
    import smmi0_pkg::*;
#(
    parameter int W = 32
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  t_lane_kind   i_kind,
    output logic [W-1:0] o_res
);

    logic [W:0]   sum;
    logic [W:0]   diff;
    logic         gt;
    logic         ge;
    logic [W-1:0] smax;
    logic [W-1:0] smin;
    logic [W-1:0] sat_sum;
    logic [W-1:0] sat_diff;

    assign sum  = {i_a[W-1], i_a} + {i_b[W-1], i_b};
    assign diff = {i_a[W-1], i_a} - {i_b[W-1], i_b};
    assign gt   = $signed(i_a) > $signed(i_b);
    assign ge   = $signed(i_a) >= $signed(i_b);
    assign smax = {1'b0, {(W-1){1'b1}}};
    assign smin = {1'b1, {(W-1){1'b0}}};

    // overflow when the extra sign bit disagrees with the lane's top bit
    assign sat_sum  = (sum[W] != sum[W-1])   ? (sum[W]  ? smin : smax) : sum[W-1:0];
    assign sat_diff = (diff[W] != diff[W-1]) ? (diff[W] ? smin : smax) : diff[W-1:0];

    always_comb begin
        case (i_kind)
            LK_ADD:  o_res = sum[W-1:0];
            LK_SUB:  o_res = diff[W-1:0];
            LK_CGT:  o_res = {W{gt}};
            LK_MAX:  o_res = ge ? i_a : i_b;
            LK_ADDS: o_res = sat_sum;
            LK_SUBS: o_res = sat_diff;
            default: o_res = '0;
        endcase
    end

endmodule

// ----- src/smmi0_exec.sv -----
module smmi0_exec
    import smmi0_pkg::*;
(
    input  t_in_item  i_item,
    output t_out_item o_item
);

    logic [4:0]   op;
    logic [127:0] a;
    logic [127:0] b;
    t_lane_kind   kind;
    logic [127:0] w_res;
    logic [127:0] h_res;
    logic [127:0] b_res;
    logic [127:0] extl_w, extl_h, extl_b;
    logic [127:0] pac_w, pac_h, pac_b;
    logic [127:0] ext5, pac5;
    logic [127:0] res;
    logic         rsvd;

    assign op = i_item.action;
    assign a  = {i_item.src_a_hi, i_item.src_a_lo};
    assign b  = {i_item.src_b_hi, i_item.src_b_lo};

    // upper half of the map selects the saturating kinds
    assign kind = t_lane_kind'({op[4], op[1:0]});

    genvar k;
    generate
        for (k = 0; k < 4; k++) begin : g_w
            smmi0_lane #(.W(32)) u_lane (
                .i_a(a[32*k +: 32]), .i_b(b[32*k +: 32]), .i_kind(kind),
                .o_res(w_res[32*k +: 32])
            );
        end
        for (k = 0; k < 8; k++) begin : g_h
            smmi0_lane #(.W(16)) u_lane (
                .i_a(a[16*k +: 16]), .i_b(b[16*k +: 16]), .i_kind(kind),
                .o_res(h_res[16*k +: 16])
            );
        end
        for (k = 0; k < 16; k++) begin : g_b
            smmi0_lane #(.W(8)) u_lane (
                .i_a(a[8*k +: 8]), .i_b(b[8*k +: 8]), .i_kind(kind),
                .o_res(b_res[8*k +: 8])
            );
        end
    endgenerate

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            extl_w[64*i +: 32]      = b[32*i +: 32];
            extl_w[64*i + 32 +: 32] = a[32*i +: 32];
            pac_w[32*i +: 32]       = b[64*i +: 32];
            pac_w[64 + 32*i +: 32]  = a[64*i +: 32];
        end
        for (int i = 0; i < 4; i++) begin
            extl_h[32*i +: 16]      = b[16*i +: 16];
            extl_h[32*i + 16 +: 16] = a[16*i +: 16];
            pac_h[16*i +: 16]       = b[32*i +: 16];
            pac_h[64 + 16*i +: 16]  = a[32*i +: 16];
            ext5[32*i +: 32] = {b[32*i + 15], 7'd0,
                                b[32*i + 10 +: 5], 3'd0,
                                b[32*i + 5 +: 5], 3'd0,
                                b[32*i +: 5], 3'd0};
            pac5[32*i +: 32] = {16'd0, b[32*i + 31],
                                b[32*i + 19 +: 5],
                                b[32*i + 11 +: 5],
                                b[32*i + 3 +: 5]};
        end
        for (int i = 0; i < 8; i++) begin
            extl_b[16*i +: 8]     = b[8*i +: 8];
            extl_b[16*i + 8 +: 8] = a[8*i +: 8];
            pac_b[8*i +: 8]       = b[16*i +: 8];
            pac_b[64 + 8*i +: 8]  = a[16*i +: 8];
        end
    end

    always_comb begin
        rsvd = 1'b0;
        unique case (op) inside
            OP_PADDW, OP_PSUBW, OP_PCGTW, OP_PMAXW, OP_PADDSW, OP_PSUBSW:
                res = w_res;
            OP_PADDH, OP_PSUBH, OP_PCGTH, OP_PMAXH, OP_PADDSH, OP_PSUBSH:
                res = h_res;
            OP_PADDB, OP_PSUBB, OP_PCGTB, OP_PADDSB, OP_PSUBSB:
                res = b_res;
            OP_PEXTLW: res = extl_w;
            OP_PEXTLH: res = extl_h;
            OP_PEXTLB: res = extl_b;
            OP_PPACW:  res = pac_w;
            OP_PPACH:  res = pac_h;
            OP_PPACB:  res = pac_b;
            OP_PEXT5:  res = ext5;
            OP_PPAC5:  res = pac5;
            default: begin
                res  = '0;
                rsvd = 1'b1;
            end
        endcase
    end

    assign o_item.result_lo   = res[63:0];
    assign o_item.result_hi   = res[127:64];
    assign o_item.reserved_op = rsvd;

endmodule

// ----- src/simd128_mmi0_alu.sv -----
// 128-bit packed ALU for the MMI0 group: lane add/sub (wrapping and signed
// saturating), signed compare-greater and max, low-half interleave, even-lane
// pack and 1-5-5-5 color expand/pack. Each beat passes an input register, one
// level of lane logic and a result register; a new beat is taken every cycle
// while o_in_stall is low. Input stall rises only when both the input and
// result registers are full and the result side stalls. Reserved opcodes
// return zero data with reserved_op set. No state is kept between beats.
module simd128_mmi0_alu
    import smmi0_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    logic      r_in_valid, n_in_valid;
    t_in_item  r_in;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out;
    t_out_item exec_item;
    logic      in_take;
    logic      s1_move;

    smmi0_exec u_exec (
        .i_item(r_in),
        .o_item(exec_item)
    );

    assign s1_move    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;
    assign in_take    = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_take) begin
            n_in_valid = 1'b1;
        end else if (s1_move) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (s1_move) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
        if (s1_move) begin
            r_out <= exec_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- src/smmi0_checker.sv -----
module smmi0_checker
    import smmi0_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    // reserved opcode never carries data
    a_rsvd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.reserved_op |->
            o_out_data.result_lo == 64'd0 && o_out_data.result_hi == 64'd0)
        else $error("reserved beat with nonzero data");

    // input side backs up only behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stall without stalled result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

endmodule

bind simd128_mmi0_alu smmi0_checker u_chk (.*);

// ----- bench/tb_simd128_mmi0_alu.sv -----
module tb_simd128_mmi0_alu;
    timeunit 1ns;
    timeprecision 1ps;

    import smmi0_pkg::*;

    localparam int NUM_VEC        = 27;
    localparam int NUM_RAND       = 830;
    localparam int CALM_FIRST     = NUM_VEC + 300;
    localparam int CALM_LAST      = NUM_VEC + 450;
    localparam int IDLE_PCT       = 21;
    localparam int WATCHDOG_LIMIT = 1000;

    // unassigned opcodes used by the directed rows
    localparam logic [4:0] OP_RSV11 = 5'd11;
    localparam logic [4:0] OP_RSV28 = 5'd28;

    localparam logic [127:0] ONES   = '1;
    localparam logic [127:0] ZERO   = '0;
    localparam logic [127:0] MIX    = 128'h0123456789abcdef_fedcba9876543210;
    localparam logic [127:0] W_ONE  = {4{32'h00000001}};
    localparam logic [127:0] W_MAXP = {4{32'h7fffffff}};
    localparam logic [127:0] W_MINN = {4{32'h80000000}};
    localparam logic [127:0] H_ONE  = {8{16'h0001}};
    localparam logic [127:0] H_MAXP = {8{16'h7fff}};
    localparam logic [127:0] H_MINN = {8{16'h8000}};
    localparam logic [127:0] B_MAXP = {16{8'h7f}};
    localparam logic [127:0] B_MINN = {16{8'h80}};

    typedef enum logic [2:0] {
        SH_LANE,
        SH_EXTL,
        SH_PACK,
        SH_EXP5,
        SH_PAC5,
        SH_NONE
    } t_shape;

    typedef struct packed {
        logic [4:0]   op;
        logic [127:0] a;
        logic [127:0] b;
        logic         known;
        logic [127:0] res;
        logic         rsv;
    } t_vec;

    // rows with known = 0 are checked against the predictor
    localparam t_vec DIRECTED [NUM_VEC] = '{
        '{OP_PADDW,  ONES,   W_ONE,  1'b1, ZERO,               1'b0},
        '{OP_PSUBW,  ZERO,   W_ONE,  1'b1, ONES,               1'b0},
        '{OP_PCGTW,  W_MAXP, W_MINN, 1'b1, ONES,               1'b0},
        '{OP_PMAXW,  W_MINN, W_MAXP, 1'b1, W_MAXP,             1'b0},
        '{OP_PADDH,  H_MAXP, H_ONE,  1'b1, H_MINN,             1'b0},
        '{OP_PSUBH,  H_MINN, H_ONE,  1'b1, H_MAXP,             1'b0},
        '{OP_PCGTH,  H_MINN, H_MAXP, 1'b1, ZERO,               1'b0},
        '{OP_PMAXH,  MIX,    ~MIX,   1'b0, ZERO,               1'b0},
        '{OP_PADDB,  B_MAXP, B_MAXP, 1'b1, {16{8'hfe}},        1'b0},
        '{OP_PSUBB,  MIX,    ONES,   1'b0, ZERO,               1'b0},
        '{OP_PCGTB,  MIX,    B_MINN, 1'b0, ZERO,               1'b0},
        '{OP_RSV11,  ONES,   ONES,   1'b1, ZERO,               1'b1},
        '{OP_PADDSW, W_MAXP, W_ONE,  1'b1, W_MAXP,             1'b0},
        '{OP_PSUBSW, W_MINN, W_ONE,  1'b1, W_MINN,             1'b0},
        '{OP_PEXTLW, MIX,    ~MIX,   1'b0, ZERO,               1'b0},
        '{OP_PPACW,  MIX,    ~MIX,   1'b0, ZERO,               1'b0},
        '{OP_PADDSH, H_MINN, H_MINN, 1'b1, H_MINN,             1'b0},
        '{OP_PSUBSH, H_MAXP, ONES,   1'b1, H_MAXP,             1'b0},
        '{OP_PEXTLH, MIX,    ~MIX,   1'b0, ZERO,               1'b0},
        '{OP_PPACH,  MIX,    ~MIX,   1'b0, ZERO,               1'b0},
        '{OP_PADDSB, B_MAXP, B_MAXP, 1'b1, B_MAXP,             1'b0},
        '{OP_PSUBSB, B_MINN, B_MAXP, 1'b1, B_MINN,             1'b0},
        '{OP_PEXTLB, MIX,    ~MIX,   1'b0, ZERO,               1'b0},
        '{OP_PPACB,  MIX,    ~MIX,   1'b0, ZERO,               1'b0},
        '{OP_RSV28,  ONES,   ONES,   1'b1, ZERO,               1'b1},
        '{OP_PEXT5,  ZERO,   ONES,   1'b1, {4{32'h80f8f8f8}},  1'b0},
        '{OP_PPAC5,  ZERO,   ONES,   1'b1, {4{32'h0000ffff}},  1'b0}
    };

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    t_out_item   pending_results[$];
    bit          calm;
    bit [31:0]   ops_seen;
    int unsigned beats_sent;
    int unsigned results_checked;
    int unsigned reserved_seen;
    int unsigned mismatches;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    simd128_mmi0_alu u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    function automatic longint lane_signed(logic [31:0] x, int w);
        longint v;
        v = longint'({32'b0, x}) & ((64'sd1 << w) - 1);
        if (x[w-1])
            v -= (64'sd1 << w);
        return v;
    endfunction

    function automatic logic [31:0] lane_calc(t_lane_kind kind, logic [31:0] x,
                                              logic [31:0] y, int w);
        longint      sx;
        longint      sy;
        longint      s;
        longint      top;
        logic [31:0] m;
        m   = 32'((64'd1 << w) - 1);
        sx  = lane_signed(x, w);
        sy  = lane_signed(y, w);
        top = (64'sd1 << (w - 1)) - 1;
        case (kind)
            LK_ADD:  return (x + y) & m;
            LK_SUB:  return (x - y) & m;
            LK_CGT:  return (sx > sy) ? m : 32'd0;
            LK_MAX:  return ((sx >= sy) ? x : y) & m;
            LK_ADDS: s = sx + sy;
            default: s = sx - sy;
        endcase
        if (s > top)
            s = top;
        if (s < -top - 1)
            s = -top - 1;
        return 32'(s) & m;
    endfunction

    function automatic t_out_item mmi0_execute(t_in_item it);
        logic [127:0] a;
        logic [127:0] b;
        logic [127:0] r;
        logic [127:0] m;
        logic [31:0]  x;
        t_lane_kind   kind;
        t_shape       shape;
        int           w;
        int           n;
        t_out_item    res;
        a     = {it.src_a_hi, it.src_a_lo};
        b     = {it.src_b_hi, it.src_b_lo};
        r     = '0;
        kind  = LK_ADD;
        shape = SH_LANE;
        case (it.action)
            OP_PADDW, OP_PADDH, OP_PADDB:    kind = LK_ADD;
            OP_PSUBW, OP_PSUBH, OP_PSUBB:    kind = LK_SUB;
            OP_PCGTW, OP_PCGTH, OP_PCGTB:    kind = LK_CGT;
            OP_PMAXW, OP_PMAXH:              kind = LK_MAX;
            OP_PADDSW, OP_PADDSH, OP_PADDSB: kind = LK_ADDS;
            OP_PSUBSW, OP_PSUBSH, OP_PSUBSB: kind = LK_SUBS;
            OP_PEXTLW, OP_PEXTLH, OP_PEXTLB: shape = SH_EXTL;
            OP_PPACW, OP_PPACH, OP_PPACB:    shape = SH_PACK;
            OP_PEXT5:                        shape = SH_EXP5;
            OP_PPAC5:                        shape = SH_PAC5;
            default:                         shape = SH_NONE;
        endcase
        case (it.action)
            OP_PADDW, OP_PSUBW, OP_PCGTW, OP_PMAXW,
            OP_PADDSW, OP_PSUBSW, OP_PEXTLW, OP_PPACW: w = 32;
            OP_PADDH, OP_PSUBH, OP_PCGTH, OP_PMAXH,
            OP_PADDSH, OP_PSUBSH, OP_PEXTLH, OP_PPACH: w = 16;
            default:                                   w = 8;
        endcase
        n = 128 / w;
        m = (128'd1 << w) - 1;
        case (shape)
            SH_LANE: begin
                for (int k = 0; k < n; k++)
                    r |= 128'(lane_calc(kind, 32'((a >> (k * w)) & m),
                                        32'((b >> (k * w)) & m), w)) << (k * w);
            end
            SH_EXTL: begin
                // low half interleaved, B in the even lanes
                for (int k = 0; k < n / 2; k++) begin
                    r |= ((b >> (k * w)) & m) << (2 * k * w);
                    r |= ((a >> (k * w)) & m) << ((2 * k + 1) * w);
                end
            end
            SH_PACK: begin
                for (int k = 0; k < n / 2; k++) begin
                    r |= ((b >> (2 * k * w)) & m) << (k * w);
                    r |= ((a >> (2 * k * w)) & m) << ((n / 2 + k) * w);
                end
            end
            SH_EXP5: begin
                for (int k = 0; k < 4; k++) begin
                    x = b[k*32 +: 32];
                    r[k*32 +: 32] = {x[15], 7'b0, x[14:10], 3'b0, x[9:5], 3'b0,
                                     x[4:0], 3'b0};
                end
            end
            SH_PAC5: begin
                for (int k = 0; k < 4; k++) begin
                    x = b[k*32 +: 32];
                    r[k*32 +: 32] = {16'b0, x[31], x[23:19], x[15:11], x[7:3]};
                end
            end
            default: ;
        endcase
        res.result_lo   = r[63:0];
        res.result_hi   = r[127:64];
        res.reserved_op = (shape == SH_NONE);
        return res;
    endfunction

    // half the operands get lanes pinned to boundary values so that
    // saturation, wrap and compare edges come up often
    function automatic logic [127:0] pick_operand();
        logic [127:0] v;
        logic [127:0] m;
        logic [127:0] lane;
        int           w;
        v = {$urandom, $urandom, $urandom, $urandom};
        if ($urandom_range(0, 1) == 0)
            return v;
        w = 8 << $urandom_range(0, 2);
        m = (128'd1 << w) - 1;
        for (int k = 0; k < 128 / w; k++) begin
            case ($urandom_range(0, 5))
                0:       lane = '0;
                1:       lane = 128'd1;
                2:       lane = (128'd1 << (w - 1)) - 1;
                3:       lane = 128'd1 << (w - 1);
                4:       lane = m;
                default: lane = (v >> (k * w)) & m;
            endcase
            v = (v & ~(m << (k * w))) | (lane << (k * w));
        end
        return v;
    endfunction

    always @(negedge clk) begin
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end

    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                if (mismatches < 10)
                    $display("[%0t] result beat with nothing pending: lo=%h hi=%h rsv=%b",
                             $realtime, out_data.result_lo, out_data.result_hi,
                             out_data.reserved_op);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (out_data.reserved_op === 1'b1)
                    reserved_seen++;
                if (out_data.result_lo !== want.result_lo ||
                    out_data.result_hi !== want.result_hi ||
                    out_data.reserved_op !== want.reserved_op) begin
                    if (mismatches < 10) begin
                        $display("[%0t] mismatch on result %0d", $realtime, results_checked);
                        $display("    result_lo   exp %h got %h", want.result_lo,
                                 out_data.result_lo);
                        $display("    result_hi   exp %h got %h", want.result_hi,
                                 out_data.result_hi);
                        $display("    reserved_op exp %b got %b", want.reserved_op,
                                 out_data.reserved_op);
                    end
                    mismatches++;
                end
            end
        end
    end

    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no beat moved for %0d cycles, %0d results still pending",
                 WATCHDOG_LIMIT, pending_results.size());
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        t_in_item  beat;
        t_out_item want;
        t_vec      row;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        in_data         = '0;
        calm            = 1'b0;
        ops_seen        = '0;
        beats_sent      = 0;
        results_checked = 0;
        reserved_seen   = 0;
        mismatches      = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int idx = 0; idx < NUM_VEC + NUM_RAND; idx++) begin
            if (idx < NUM_VEC) begin
                row             = DIRECTED[idx];
                beat.action     = row.op;
                beat.src_a_lo   = row.a[63:0];
                beat.src_a_hi   = row.a[127:64];
                beat.src_b_lo   = row.b[63:0];
                beat.src_b_hi   = row.b[127:64];
                want.result_lo   = row.res[63:0];
                want.result_hi   = row.res[127:64];
                want.reserved_op = row.rsv;
                if (!row.known)
                    want = mmi0_execute(beat);
            end else begin
                beat.action = 5'($urandom_range(0, 31));
                {beat.src_a_hi, beat.src_a_lo} = pick_operand();
                {beat.src_b_hi, beat.src_b_lo} = pick_operand();
                want = mmi0_execute(beat);
            end

            @(negedge clk);
            while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid <= 1'b1;
            in_data  <= beat;
            do
                @(posedge clk);
            while (in_stall);
            pending_results.push_back(want);
            ops_seen[beat.action] = 1'b1;
            beats_sent++;
            calm = (idx + 1 >= CALM_FIRST) && (idx + 1 < CALM_LAST);
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("%0d instruction beats issued (%0d directed), %0d of 32 opcodes exercised",
                 beats_sent, NUM_VEC, $countones(ops_seen));
        $display("%0d results checked, %0d with reserved opcode, %0d mismatches",
                 results_checked, reserved_seen, mismatches);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
